/* rtl/ubrf_pkg.sv */
// ----------------------------------------------------------------------------
// ubrf_pkg: shared types and constants of the UART bridge register file
// Event codes, register addresses, baud divisor table and the result record.
// ----------------------------------------------------------------------------
package ubrf_pkg;

  // Receive ring geometry.
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // Event codes carried on the input kind field.
  typedef enum logic [2:0] {
    OP_SELECT  = 3'd0,
    OP_WRITE   = 3'd1,
    OP_END     = 3'd2,
    OP_READ    = 3'd3,
    OP_RX_BYTE = 3'd4,
    OP_TX_DONE = 3'd5
  } ubrf_op_t;

  // Register pointer values.
  localparam logic [7:0] ADDR_THR  = 8'h00;
  localparam logic [7:0] ADDR_IER  = 8'h08;
  localparam logic [7:0] ADDR_FCR  = 8'h10;
  localparam logic [7:0] ADDR_LCR  = 8'h18;
  localparam logic [7:0] ADDR_MCR  = 8'h20;
  localparam logic [7:0] ADDR_LSR  = 8'h28;
  localparam logic [7:0] ADDR_SPR  = 8'h38;
  localparam logic [7:0] ADDR_BAUD = 8'h0d << 3;

  // Read values for status and unmapped registers.
  localparam logic [7:0] LSR_BASE      = 8'h60;
  localparam logic [7:0] UNMAPPED_READ = 8'hFF;

  // Bit positions inside written bytes.
  localparam int MCR_MANUAL_BIT = 1;
  localparam int FCR_RX_RST_BIT = 1;

  // Baud divisor table: codes at or above BAUD_CODES are ignored.
  localparam logic [3:0] BAUD_CODES     = 4'd6;
  localparam logic [7:0] BAUD_INT_RESET = 8'd208;
  localparam logic [5:0] BAUD_FRAC_RESET = 6'd21;

  function automatic logic [7:0] baud_int(input logic [3:0] code);
    logic [7:0] v;
    case (code)
      4'd0:    v = 8'd208;
      4'd1:    v = 8'd17;
      4'd2:    v = 8'd104;
      4'd3:    v = 8'd52;
      4'd4:    v = 8'd34;
      4'd5:    v = 8'd64;
      default: v = BAUD_INT_RESET;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] baud_frac(input logic [3:0] code);
    logic [5:0] v;
    case (code)
      4'd0:    v = 6'd21;
      4'd1:    v = 6'd23;
      4'd2:    v = 6'd11;
      4'd3:    v = 6'd5;
      4'd4:    v = 6'd46;
      4'd5:    v = 6'd0;
      default: v = BAUD_FRAC_RESET;
    endcase
    return v;
  endfunction

  // Ring pointer advance with wrap at the ring depth.
  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
    logic [RING_AW-1:0] v;
    if (p == RING_AW'(RING_DEPTH - 1)) begin
      v = '0;
    end else begin
      v = p + RING_AW'(1);
    end
    return v;
  endfunction

  // Result of one event, as it leaves the register file.
  typedef struct packed {
    logic       rx_dropped;
    logic [5:0] baud_fraction;
    logic [7:0] baud_integer;
    logic       drive_enable;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic [7:0] read_data;
  } ubrf_res_t;

endpackage

/* rtl/uart_bridge_register_file_unit.sv */
// ----------------------------------------------------------------------------
// uart_bridge_register_file_unit: register side of a bus-to-UART bridge
// Stream wrapper around the register file with a result stage and an
// output register.
// ----------------------------------------------------------------------------
// Each input beat is one event (kind in s_axis_tuser) and produces exactly one
// output beat. Events are taken at one per cycle while the output side keeps
// up: state is updated at the accepting edge, the result waits in a stage
// register while a receive-ring read completes in the ring RAM, and then moves
// to the output register when the output side is ready. The input keeps
// accepting while the output waits, until both the stage and the output
// register hold a beat.
module uart_bridge_register_file_unit import ubrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data, [8] uart_busy
  input  logic [15:0] s_axis_tdata,
  // [2:0] operation
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [15:8] tx_data, [16] tx_valid, [17] drive_enable,
  // [25:18] baud_integer, [31:26] baud_fraction, [32] rx_dropped
  output logic [39:0] m_axis_tdata
);

  logic       accept;
  ubrf_res_t  step_res;
  logic       step_pop;
  logic [7:0] ring_rdata;

  logic       s1_valid;
  ubrf_res_t  s1_res;
  logic       s1_pop;
  logic       s1_adv;
  ubrf_res_t  s1_out;
  ubrf_res_t  out_res;

  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ubrf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (ubrf_op_t'(s_axis_tuser)),
    .data      (s_axis_tdata[7:0]),
    .uart_busy (s_axis_tdata[8]),
    .res       (step_res),
    .ring_pop  (step_pop),
    .ring_rdata(ring_rdata)
  );

  // Stage control: the stage fills on accept and drains into the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Staged result on its way out; a ring pop takes its byte from the RAM.
  always_comb begin
    s1_out = s1_res;
    if (s1_pop) begin
      s1_out.read_data = ring_rdata;
    end
  end

  // Stage and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= step_res;
      s1_pop <= step_pop;
    end
    if (s1_adv) begin
      out_res <= s1_out;
    end
  end

  assign m_axis_tdata = {7'd0, out_res};

`ifndef SYNTHESIS
  // A beat never both transmits and reports a dropped byte.
  a_tx_drop_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_res.tx_valid && out_res.rx_dropped))
    else $error("result carries both a transmit byte and a drop flag");

  // A stalled output keeps the staged beat in place.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_axis_tvalid && !m_axis_tready) |=> s1_valid)
    else $error("staged beat lost while output stalled");

  // A ring pop stage never carries a register read value.
  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_pop) |-> (s1_res.read_data == 8'd0 && !s1_res.tx_valid))
    else $error("ring pop beat carries other data");
`endif

endmodule

/* rtl/ubrf_ram.sv */
// ----------------------------------------------------------------------------
// ubrf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ubrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ubrf_regs.sv */
// ----------------------------------------------------------------------------
// ubrf_regs: register state and event decode
// Applies one event per accepted beat to the registers and the receive ring,
// and forms the result record. A ring pop's byte comes from a registered RAM read.
// ----------------------------------------------------------------------------
module ubrf_regs import ubrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  ubrf_op_t   op,
  input  logic [7:0] data,
  input  logic       uart_busy,
  output ubrf_res_t  res,
  output logic       ring_pop,
  output logic [7:0] ring_rdata
);

  logic [RING_AW-1:0] head, head_next;
  logic [RING_AW-1:0] tail, tail_next;
  logic [7:0]         reg_pointer, reg_pointer_next;
  logic [7:0]         ier, ier_next;
  logic [7:0]         lcr, lcr_next;
  logic [7:0]         mcr, mcr_next;
  logic [7:0]         scratch, scratch_next;
  logic               auto_tx, auto_tx_next;
  logic               done_armed, done_armed_next;
  logic               drive_level, drive_level_next;
  logic [7:0]         div_int, div_int_next;
  logic [5:0]         div_frac, div_frac_next;

  logic               ring_we;
  logic               nonempty;
  logic               mcr_manual;
  logic [RING_AW-1:0] head_adv;

  assign nonempty   = (head != tail);
  assign mcr_manual = mcr[MCR_MANUAL_BIT];
  assign head_adv   = ring_next(head);

  // Event decode and next-state logic.
  always_comb begin
    head_next        = head;
    tail_next        = tail;
    reg_pointer_next = reg_pointer;
    ier_next         = ier;
    lcr_next         = lcr;
    mcr_next         = mcr;
    scratch_next     = scratch;
    auto_tx_next     = auto_tx;
    done_armed_next  = done_armed;
    drive_level_next = drive_level;
    div_int_next     = div_int;
    div_frac_next    = div_frac;
    ring_we          = 1'b0;
    ring_pop         = 1'b0;
    res              = '0;

    case (op)
      OP_SELECT: begin
        reg_pointer_next = data;
        if (data == ADDR_THR) begin
          done_armed_next  = 1'b0;
          auto_tx_next     = 1'b1;
          drive_level_next = 1'b1;
        end
      end
      OP_WRITE: begin
        case (reg_pointer)
          ADDR_BAUD: begin
            if (data[3:0] < BAUD_CODES) begin
              div_int_next  = baud_int(data[3:0]);
              div_frac_next = baud_frac(data[3:0]);
            end
          end
          ADDR_THR: begin
            res.tx_data  = data;
            res.tx_valid = 1'b1;
          end
          ADDR_IER: ier_next = data;
          ADDR_LCR: lcr_next = data;
          ADDR_FCR: begin
            if (data[FCR_RX_RST_BIT]) begin
              tail_next = head;
            end
          end
          ADDR_MCR: begin
            mcr_next         = data;
            drive_level_next = data[MCR_MANUAL_BIT];
          end
          ADDR_SPR: scratch_next = data;
          default: ;
        endcase
      end
      OP_END: begin
        if (reg_pointer == ADDR_THR) begin
          if (uart_busy) begin
            done_armed_next = 1'b1;
          end else begin
            if (!mcr_manual) begin
              drive_level_next = 1'b0;
            end
            auto_tx_next = 1'b0;
          end
        end
      end
      OP_READ: begin
        case (reg_pointer)
          ADDR_THR: begin
            if (nonempty) begin
              ring_pop  = 1'b1;
              tail_next = ring_next(tail);
            end
          end
          ADDR_LSR: res.read_data = LSR_BASE | {7'd0, nonempty};
          ADDR_IER: res.read_data = ier;
          ADDR_LCR: res.read_data = lcr;
          ADDR_MCR: res.read_data = mcr;
          ADDR_SPR: res.read_data = scratch;
          default:  res.read_data = UNMAPPED_READ;
        endcase
      end
      OP_RX_BYTE: begin
        if (head_adv != tail) begin
          ring_we   = 1'b1;
          head_next = head_adv;
        end else begin
          res.rx_dropped = 1'b1;
        end
      end
      OP_TX_DONE: begin
        if (done_armed) begin
          if (auto_tx && !mcr_manual) begin
            drive_level_next = 1'b0;
          end
          auto_tx_next    = 1'b0;
          done_armed_next = 1'b0;
        end
      end
      default: ;
    endcase

    res.drive_enable  = drive_level_next;
    res.baud_integer  = div_int_next;
    res.baud_fraction = div_frac_next;
  end

  // State registers, updated on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      reg_pointer <= '0;
      ier         <= '0;
      lcr         <= '0;
      mcr         <= '0;
      scratch     <= '0;
      auto_tx     <= 1'b0;
      done_armed  <= 1'b0;
      drive_level <= 1'b0;
      div_int     <= BAUD_INT_RESET;
      div_frac    <= BAUD_FRAC_RESET;
    end else if (accept) begin
      head        <= head_next;
      tail        <= tail_next;
      reg_pointer <= reg_pointer_next;
      ier         <= ier_next;
      lcr         <= lcr_next;
      mcr         <= mcr_next;
      scratch     <= scratch_next;
      auto_tx     <= auto_tx_next;
      done_armed  <= done_armed_next;
      drive_level <= drive_level_next;
      div_int     <= div_int_next;
      div_frac    <= div_frac_next;
    end
  end

  // Receive ring storage: written at head, read at tail.
  ubrf_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (accept && ring_we),
    .waddr(head),
    .wdata(data),
    .re   (accept),
    .raddr(tail),
    .rdata(ring_rdata)
  );

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: stream-level check of the UART bridge register file
// A directed table covers reset values, the status and unmapped reads, the
// transmit handshake, the baud table and the reserved event codes. Random
// event sequences follow. Every beat taken by the block updates a local model
// of the registers and the receive ring, and each output beat is compared
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;
  import ubrf_pkg::*;

  // Reserved event codes: the block must leave its state alone.
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  localparam int RANDOM_EVENTS = 1000;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_MAX    = 10;

  // Divisor pairs selected by the baud codes.
  localparam logic [7:0] DIV_INT_TAB [6]  = '{8'd208, 8'd17, 8'd104, 8'd52, 8'd34, 8'd64};
  localparam logic [5:0] DIV_FRAC_TAB [6] = '{6'd21, 6'd23, 6'd11, 6'd5, 6'd46, 6'd0};

  // One directed event; the result is taken from the row only when typed is set.
  typedef struct packed {
    logic       typed;
    logic [2:0] op;
    logic [7:0] data;
    logic       busy;
    ubrf_res_t  res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam logic [32:0] PREDICTED = '0;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Reset state: pointer on the receive register, ring empty.
    {1'b1, OP_READ,    8'h00,     1'b0, {1'b0, 6'd21, 8'd208, 1'b0, 1'b0, 8'h00, 8'h00}},
    {1'b1, OP_SELECT,  ADDR_LSR,  1'b0, {1'b0, 6'd21, 8'd208, 1'b0, 1'b0, 8'h00, 8'h00}},
    {1'b1, OP_READ,    8'h00,     1'b0, {1'b0, 6'd21, 8'd208, 1'b0, 1'b0, 8'h00, 8'h60}},
    // Unmapped pointer at the top of the byte range.
    {1'b1, OP_SELECT,  8'hFF,     1'b0, {1'b0, 6'd21, 8'd208, 1'b0, 1'b0, 8'h00, 8'h00}},
    {1'b1, OP_READ,    8'h00,     1'b0, {1'b0, 6'd21, 8'd208, 1'b0, 1'b0, 8'h00, 8'hFF}},
    {1'b0, OP_WRITE,   8'hFF,     1'b1, PREDICTED},
    // Two received bytes, then the status shows data.
    {1'b0, OP_RX_BYTE, 8'h00,     1'b0, PREDICTED},
    {1'b0, OP_RX_BYTE, 8'hFF,     1'b1, PREDICTED},
    {1'b0, OP_SELECT,  ADDR_LSR,  1'b0, PREDICTED},
    {1'b0, OP_READ,    8'h00,     1'b0, PREDICTED},
    // Transmit with the UART still busy, then transmit done.
    {1'b0, OP_SELECT,  ADDR_THR,  1'b0, PREDICTED},
    {1'b0, OP_WRITE,   8'hA5,     1'b0, PREDICTED},
    {1'b0, OP_END,     8'h00,     1'b1, PREDICTED},
    {1'b0, OP_TX_DONE, 8'h00,     1'b0, PREDICTED},
    // Pop both bytes from the ring.
    {1'b0, OP_READ,    8'h00,     1'b0, PREDICTED},
    {1'b0, OP_READ,    8'hFF,     1'b1, PREDICTED},
    // Manual driver enable, baud table and an invalid baud code.
    {1'b0, OP_SELECT,  ADDR_MCR,  1'b0, PREDICTED},
    {1'b0, OP_WRITE,   8'h02,     1'b0, PREDICTED},
    {1'b0, OP_SELECT,  ADDR_BAUD, 1'b0, PREDICTED},
    {1'b0, OP_WRITE,   8'h05,     1'b0, PREDICTED},
    {1'b0, OP_WRITE,   8'h0F,     1'b0, PREDICTED},
    // FIFO reset and the reserved event codes.
    {1'b0, OP_SELECT,  ADDR_FCR,  1'b0, PREDICTED},
    {1'b0, OP_WRITE,   8'h02,     1'b0, PREDICTED},
    {1'b0, OP_RSVD_6,  8'hFF,     1'b1, PREDICTED},
    {1'b0, OP_RSVD_7,  8'h00,     1'b0, PREDICTED}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [7:0] data, [8] uart_busy
  logic [2:0]  s_axis_tuser = '0;  // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] read_data, [15:8] tx_data, [16] tx_valid, [17] drive_enable,
  // [25:18] baud_integer, [31:26] baud_fraction, [32] rx_dropped
  logic [39:0] m_axis_tdata;

  uart_bridge_register_file_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Local copy of the register file state.
  logic [7:0]         rx_copy [RING_DEPTH];
  logic [RING_AW-1:0] rx_head = '0;
  logic [RING_AW-1:0] rx_tail = '0;
  logic [7:0]         ptr_q = '0;
  logic [7:0]         ier_q = '0;
  logic [7:0]         lcr_q = '0;
  logic [7:0]         mcr_q = '0;
  logic [7:0]         spr_q = '0;
  logic               auto_tx_q = 1'b0;
  logic               armed_q = 1'b0;
  logic               drive_q = 1'b0;
  logic [7:0]         div_int_q = 8'd208;
  logic [5:0]         div_frac_q = 6'd21;

  ubrf_res_t pending_results [$];
  int        mismatch_count = 0;
  int        results_seen = 0;
  int        events_sent = 0;
  int        burst_left = 0;

  // Apply one event to the local state and return the result it causes.
  function automatic ubrf_res_t bridge_event(input logic [2:0] op, input logic [7:0] d,
                                             input logic busy);
    ubrf_res_t          r;
    logic               manual;
    logic [RING_AW-1:0] head_next;
    r = '0;
    manual = mcr_q[MCR_MANUAL_BIT];
    head_next = RING_AW'((int'(rx_head) + 1) % RING_DEPTH);
    case (op)
      OP_SELECT: begin
        ptr_q = d;
        if (d == ADDR_THR) begin
          armed_q = 1'b0;
          auto_tx_q = 1'b1;
          drive_q = 1'b1;
        end
      end
      OP_WRITE: begin
        case (ptr_q)
          ADDR_BAUD: begin
            if (d[3:0] < BAUD_CODES) begin
              div_int_q = DIV_INT_TAB[d[2:0]];
              div_frac_q = DIV_FRAC_TAB[d[2:0]];
            end
          end
          ADDR_THR: begin
            r.tx_data = d;
            r.tx_valid = 1'b1;
          end
          ADDR_IER: ier_q = d;
          ADDR_LCR: lcr_q = d;
          ADDR_FCR: if (d[FCR_RX_RST_BIT]) rx_tail = rx_head;
          ADDR_MCR: begin
            mcr_q = d;
            drive_q = d[MCR_MANUAL_BIT];
          end
          ADDR_SPR: spr_q = d;
          default: ;
        endcase
      end
      OP_END: begin
        if (ptr_q == ADDR_THR) begin
          if (busy) begin
            armed_q = 1'b1;
          end else begin
            if (!manual) drive_q = 1'b0;
            auto_tx_q = 1'b0;
          end
        end
      end
      OP_READ: begin
        case (ptr_q)
          ADDR_THR: begin
            if (rx_head != rx_tail) begin
              r.read_data = rx_copy[rx_tail];
              rx_tail = RING_AW'((int'(rx_tail) + 1) % RING_DEPTH);
            end
          end
          ADDR_LSR: r.read_data = LSR_BASE | {7'b0, rx_head != rx_tail};
          ADDR_IER: r.read_data = ier_q;
          ADDR_LCR: r.read_data = lcr_q;
          ADDR_MCR: r.read_data = mcr_q;
          ADDR_SPR: r.read_data = spr_q;
          default:  r.read_data = UNMAPPED_READ;
        endcase
      end
      OP_RX_BYTE: begin
        if (head_next != rx_tail) begin
          rx_copy[rx_head] = d;
          rx_head = head_next;
        end else begin
          r.rx_dropped = 1'b1;
        end
      end
      OP_TX_DONE: begin
        if (armed_q) begin
          if (auto_tx_q && !manual) drive_q = 1'b0;
          auto_tx_q = 1'b0;
          armed_q = 1'b0;
        end
      end
      default: ;
    endcase
    r.drive_enable = drive_q;
    r.baud_integer = div_int_q;
    r.baud_fraction = div_frac_q;
    return r;
  endfunction

  // Offer one beat and wait for the block to take it. Called at a rising edge.
  task automatic send_event(input logic [2:0] op, input logic [7:0] d, input logic busy,
                            input logic typed, input ubrf_res_t typed_res);
    ubrf_res_t r;
    int        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'b0, busy, d};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = bridge_event(op, d, busy);
    pending_results.push_back(typed ? typed_res : r);
    events_sent++;
  endtask

  task automatic send_random(input logic [2:0] op, input logic [7:0] d, input logic busy);
    send_event(op, d, busy, 1'b0, '0);
  endtask

  // Stop offering beats until every predicted result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Output checker.
  always @(posedge clk) begin : check_results
    ubrf_res_t got;
    ubrf_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = ubrf_res_t'(m_axis_tdata[32:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("result %0d arrived with nothing expected: %h", results_seen, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[39:33] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result %0d mismatch, expected rd=%h txd=%h txv=%b de=%b bi=%0d bf=%0d drop=%b",
                     results_seen, want.read_data, want.tx_data, want.tx_valid,
                     want.drive_enable, want.baud_integer, want.baud_fraction, want.rx_dropped);
            $display("  actual rd=%h txd=%h txv=%b de=%b bi=%0d bf=%0d drop=%b pad=%h",
                     got.read_data, got.tx_data, got.tx_valid, got.drive_enable,
                     got.baud_integer, got.baud_fraction, got.rx_dropped, m_axis_tdata[39:33]);
          end
        end
      end
    end
  end

  // Output side: rotating stall patterns and one long hold-off.
  initial begin : sink_pattern
    int   cyc;
    logic held;
    cyc = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case ((cyc / 50) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(1));
        2:       m_axis_tready <= ($urandom_range(3) != 0);
        default: m_axis_tready <= ((cyc % 5) < 2);
      endcase
    end
  end

  // Ends the run when neither side moves a beat for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck = 0;
      else
        stuck++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    int         pick;
    int         n;
    logic       mid_pause;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic       busy;
    mid_pause = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++)
      send_event(DIR_TAB[i].op, DIR_TAB[i].data, DIR_TAB[i].busy, DIR_TAB[i].typed,
                 DIR_TAB[i].res);
    wait_drained();

    // Random sequences; the first one floods the ring past full.
    pick = 99;
    while (events_sent < DIR_ROWS + RANDOM_EVENTS) begin
      if (!mid_pause && events_sent >= DIR_ROWS + RANDOM_EVENTS / 2) begin
        mid_pause = 1'b1;
        wait_drained();
      end
      if (pick < 20) begin
        // Transmit burst through THR.
        send_random(OP_SELECT, ADDR_THR, 1'($urandom_range(1)));
        n = $urandom_range(1, 4);
        repeat (n) send_random(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        busy = 1'($urandom_range(1));
        send_random(OP_END, 8'($urandom_range(255)), busy);
        if ($urandom_range(3) == 0) send_random(OP_RX_BYTE, 8'($urandom_range(255)), 1'b0);
        if ($urandom_range(9) < 7) send_random(OP_TX_DONE, 8'($urandom_range(255)), busy);
        if ($urandom_range(4) == 0) send_random(OP_TX_DONE, 8'($urandom_range(255)), 1'b0);
      end else if (pick < 45) begin
        // Register access: select, write, read back.
        case ($urandom_range(8))
          0:       addr = ADDR_IER;
          1:       addr = ADDR_FCR;
          2:       addr = ADDR_LCR;
          3:       addr = ADDR_MCR;
          4:       addr = ADDR_LSR;
          5:       addr = ADDR_SPR;
          6:       addr = ADDR_BAUD;
          7:       addr = ADDR_MCR;
          default: addr = 8'($urandom_range(255));
        endcase
        wdata = 8'($urandom_range(255));
        if (addr == ADDR_BAUD && $urandom_range(4) != 0)
          wdata = {wdata[7:4], 4'($urandom_range(7))};
        send_random(OP_SELECT, addr, 1'($urandom_range(1)));
        if ($urandom_range(4) != 0) send_random(OP_WRITE, wdata, 1'($urandom_range(1)));
        send_random(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 65) begin
        // Short run of received bytes.
        n = $urandom_range(1, 8);
        repeat (n) send_random(OP_RX_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 80) begin
        // Drain part of the ring, then check status.
        send_random(OP_SELECT, ADDR_THR, 1'b0);
        n = ($urandom_range(7) == 0) ? 70 : $urandom_range(1, 20);
        repeat (n) send_random(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_random(OP_SELECT, ADDR_LSR, 1'b0);
        send_random(OP_READ, 8'h00, 1'b0);
      end else if (pick < 83 || pick == 99) begin
        // Flood: fill the ring and keep going so bytes are dropped.
        n = $urandom_range(64, 70);
        repeat (n) send_random(OP_RX_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        // Noise: any event code, any data.
        n = $urandom_range(1, 6);
        repeat (n)
          send_random(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      pick = $urandom_range(98);
    end

    // Let the last results out, then keep watching for stray beats.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

/* uart_bridge_register_file_unit.f */
rtl/ubrf_pkg.sv
rtl/ubrf_ram.sv
rtl/ubrf_regs.sv
rtl/uart_bridge_register_file_unit.sv
tb/sv/tb.sv
